// ===== hw/rtl/ble_pkg.sv =====
// ----------------------------------------------------------------------------
// ble_pkg
// Shared sizes, codes and types of the bounded list engine.
// ----------------------------------------------------------------------------
package ble_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int DATA_WIDTH  = 32;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] MODE_APPEND  = 3'd0;
  localparam logic [2:0] MODE_REMOVE  = 3'd1;
  localparam logic [2:0] MODE_FIND    = 3'd2;
  localparam logic [2:0] MODE_DIST    = 3'd3;
  localparam logic [2:0] MODE_MINMAX  = 3'd4;
  localparam logic [2:0] MODE_REVERSE = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_BAD_INDEX = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SHIFT,
    OP_ROTATE
  } cell_op_t;

  // command broadcast to every cell
  typedef struct packed {
    cell_op_t                      op;
    logic signed [DATA_WIDTH-1:0]  value;
    logic [CNT_W-1:0]              bound;
    logic [CNT_W-1:0]              count;
  } cmd_t;

  // search token that moves one cell per cycle
  typedef struct packed {
    logic                          valid;
    logic signed [DATA_WIDTH-1:0]  va;
    logic signed [DATA_WIDTH-1:0]  vb;
    logic                          fa;
    logic                          fb;
    logic                          have;
    logic [IDX_W-1:0]              pa;
    logic [IDX_W-1:0]              pb;
    logic signed [DATA_WIDTH-1:0]  mn;
    logic signed [DATA_WIDTH-1:0]  mx;
  } qry_t;

endpackage

// ===== hw/rtl/ble_cell.sv =====
// ----------------------------------------------------------------------------
// ble_cell
// One list slot: holds an entry, follows the shared command, and processes
// the search token as it passes.
// ----------------------------------------------------------------------------
module ble_cell (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [ble_pkg::IDX_W-1:0]             slot,
  input  ble_pkg::cmd_t                         cmd,
  input  logic signed [ble_pkg::DATA_WIDTH-1:0] right,
  input  logic signed [ble_pkg::DATA_WIDTH-1:0] head,
  output logic signed [ble_pkg::DATA_WIDTH-1:0] entry,
  input  ble_pkg::qry_t                         qin,
  output ble_pkg::qry_t                         qout
);
  import ble_pkg::*;

  logic [CNT_W-1:0] slot_c;
  logic             active;
  qry_t             qry_next;

  assign slot_c = CNT_W'(slot);
  assign active = qin.valid && (slot_c < cmd.count);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        if (slot_c == cmd.count) entry <= cmd.value;
      end
      OP_SHIFT: begin
        if (slot_c >= cmd.bound) entry <= right;
      end
      OP_ROTATE: begin
        if (slot_c < cmd.bound) entry <= right;
        else if (slot_c == cmd.bound) entry <= head;
      end
      default: ;
    endcase
  end

  always_comb begin
    qry_next = qin;
    if (active) begin
      if (!qin.fa && (entry == $signed(qin.va))) begin
        qry_next.fa = 1'b1;
        qry_next.pa = slot;
      end
      if (!qin.fb && (entry == $signed(qin.vb))) begin
        qry_next.fb = 1'b1;
        qry_next.pb = slot;
      end
      if (!qin.have) begin
        qry_next.have = 1'b1;
        qry_next.mn   = entry;
        qry_next.mx   = entry;
      end else if (entry < $signed(qin.mn)) begin
        qry_next.mn = entry;
      end else if (entry > $signed(qin.mx)) begin
        qry_next.mx = entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qout.valid <= 1'b0;
    end else begin
      qout <= qry_next;
    end
  end

endmodule

// ===== hw/rtl/bounded_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// bounded_list_engine_top
// Ordered list of signed words held in a chain of cells, one entry per cell.
// ----------------------------------------------------------------------------
// One transaction in, one result out. Append, remove and the unused modes
// finish in the accept cycle and pass their result through the S_DONE
// state into the output register. Find, distance and minmax send a search
// token down the cell chain, one cell per cycle, and finish when it leaves
// the last cell. Reverse rotates a shrinking prefix of the chain once per
// cycle when two or more entries are held. A new input transaction is
// taken once the previous result sits in the output register.
module bounded_list_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,   // capacity
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,     // value_a[31:0], value_b[63:32], index[68:64]
  input  logic [2:0]  s_tuser,     // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,     // position, difference, min_value,
                                   // max_value, count [80:75]
  output logic [2:0]  m_tuser      // status
);
  import ble_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_REV, S_DONE} state_t;

  state_t                       state;
  logic [5:0]                   capacity;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             rot;
  logic [2:0]                   mode_q;
  logic [2:0]                   res_status;
  logic [4:0]                   res_pos;
  logic [5:0]                   res_diff;
  logic [31:0]                  res_min;
  logic [31:0]                  res_max;

  logic                         accept;
  logic [2:0]                   in_mode;
  logic signed [31:0]           in_va;
  logic signed [31:0]           in_vb;
  logic [4:0]                   in_idx;
  logic signed [DATA_WIDTH-1:0] va_st;
  logic signed [DATA_WIDTH-1:0] vb_st;
  logic                         full;
  logic                         bad;
  logic                         is_scan;
  cmd_t                         cmd;
  qry_t                         q [MAX_ENTRIES+1];
  logic signed [DATA_WIDTH-1:0] ent [MAX_ENTRIES];
  qry_t                         q_last;
  logic signed [15:0]           pos_delta;
  logic [4:0]                   pos_sat;
  logic [5:0]                   diff_sat;
  logic [5:0]                   count_sat;

  assign in_mode = s_tuser;
  assign in_va   = s_tdata[31:0];
  assign in_vb   = s_tdata[63:32];
  assign in_idx  = s_tdata[68:64];
  assign va_st   = DATA_WIDTH'(in_va);
  assign vb_st   = DATA_WIDTH'(in_vb);

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign full    = (16'(count) >= 16'(MAX_ENTRIES)) || (16'(count) >= 16'(capacity));
  assign bad     = 16'(in_idx) >= 16'(count);
  assign is_scan = (in_mode == MODE_FIND) || (in_mode == MODE_DIST) ||
                   (in_mode == MODE_MINMAX);

  always_comb begin
    cmd.op    = OP_HOLD;
    cmd.value = va_st;
    cmd.bound = CNT_W'(in_idx);
    cmd.count = count;
    if (accept) begin
      if ((in_mode == MODE_APPEND) && !full) cmd.op = OP_LOAD;
      if ((in_mode == MODE_REMOVE) && !bad) cmd.op = OP_SHIFT;
    end else if (state == S_REV) begin
      cmd.op    = OP_ROTATE;
      cmd.bound = rot;
    end
  end

  always_comb begin
    q[0]       = '0;
    q[0].valid = accept && is_scan;
    q[0].va    = va_st;
    q[0].vb    = vb_st;
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] nbr;
    if (i == MAX_ENTRIES - 1) begin : g_end
      assign nbr = ent[i];
    end else begin : g_mid
      assign nbr = ent[i+1];
    end
    ble_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .slot  (IDX_W'(i)),
      .cmd   (cmd),
      .right (nbr),
      .head  (ent[0]),
      .entry (ent[i]),
      .qin   (q[i]),
      .qout  (q[i+1])
    );
  end

  assign q_last = q[MAX_ENTRIES];

  always_comb begin
    pos_delta = $signed(16'(q_last.pa)) - $signed(16'(q_last.pb));
    if (pos_delta > 16'sd31) diff_sat = 6'sd31;
    else if (pos_delta < -16'sd31) diff_sat = -6'sd31;
    else diff_sat = 6'(pos_delta);
    if (32'(q_last.pa) > 32'd31) pos_sat = 5'd31;
    else pos_sat = 5'(q_last.pa);
    if (16'(count) > 16'd63) count_sat = 6'd63;
    else count_sat = 6'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      capacity <= 6'd32;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) capacity <= cfg_wdata;
      if (m_tready && (state != S_DONE)) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            mode_q     <= in_mode;
            res_pos    <= '0;
            res_diff   <= '0;
            res_min    <= '0;
            res_max    <= '0;
            rot        <= count - CNT_W'(1);
            case (in_mode)
              MODE_APPEND: begin
                res_status <= full ? ST_FULL : ST_OK;
                state      <= S_DONE;
                if (!full) count <= count + CNT_W'(1);
              end
              MODE_REMOVE: begin
                res_status <= bad ? ST_BAD_INDEX : ST_OK;
                state      <= S_DONE;
                if (!bad) count <= count - CNT_W'(1);
              end
              MODE_FIND, MODE_DIST, MODE_MINMAX: begin
                res_status <= ST_OK;
                state      <= S_SCAN;
              end
              MODE_REVERSE: begin
                res_status <= ST_OK;
                state      <= (16'(count) >= 16'd2) ? S_REV : S_DONE;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (q_last.valid) begin
            state <= S_DONE;
            case (mode_q)
              MODE_FIND: begin
                if (q_last.fa) res_pos <= pos_sat;
                else res_status <= ST_NOT_FOUND;
              end
              MODE_DIST: begin
                if (q_last.fa && q_last.fb) res_diff <= diff_sat;
                else res_status <= ST_NOT_FOUND;
              end
              default: begin
                if (q_last.have) begin
                  res_min <= 32'($signed(q_last.mn));
                  res_max <= 32'($signed(q_last.mx));
                end else begin
                  res_status <= ST_EMPTY;
                end
              end
            endcase
          end
        end
        S_REV: begin
          if (rot == CNT_W'(1)) state <= S_DONE;
          else rot <= rot - CNT_W'(1);
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {7'd0, count_sat, res_max, res_min, res_diff, res_pos};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/bounded_list_engine_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_list_engine_top_tb
// Self-checking bench for the bounded list engine.
// ----------------------------------------------------------------------------
// A shadow list predicts the reply to every accepted operation; replies are
// checked field by field in order. Directed corner cases come first, then
// random operation mixes across several capacities, with random back-pressure
// and source gaps.
module bounded_list_engine_top_tb;
  import ble_pkg::*;

  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int         STALL_LIMIT   = 4000;
  localparam int         OPS_PER_PHASE = 120;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic [4:0]         index;
  } list_op_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [4:0]         position;
    logic signed [5:0]  difference;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic [5:0]         count;
  } list_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic [2:0]  m_tuser;

  // shadow of the engine
  logic signed [DATA_WIDTH-1:0] shadow_list [MAX_ENTRIES];
  int                           shadow_len;
  logic [5:0]                   shadow_cap;

  list_op_t    op_q [$];
  list_reply_t reply_q [$];
  int n_queued = 0;
  int n_sent   = 0;
  int n_taken  = 0;
  int errors   = 0;
  int stall    = 0;
  int send_idle_pct = 9;
  int recv_idle_pct = 86;

  // stimulus-side tracking, used only to steer the random mix
  int                 gen_len = 0;
  logic [5:0]         gen_cap = 6'd32;
  logic signed [31:0] value_pool [16];

  bounded_list_engine_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #10 clk = ~clk;

  function automatic int first_pos(logic signed [DATA_WIDTH-1:0] v);
    for (int i = 0; i < shadow_len; i++) begin
      if (shadow_list[i] == v) return i;
    end
    return -1;
  endfunction

  function automatic list_reply_t apply_list_op(list_op_t op);
    list_reply_t                  r;
    logic signed [DATA_WIDTH-1:0] va, vb, lo, hi, t;
    int                           lim, pa, pb, d;
    r   = '0;
    va  = op.value_a;
    vb  = op.value_b;
    lim = (shadow_cap < MAX_ENTRIES) ? int'(shadow_cap) : MAX_ENTRIES;
    case (op.mode)
      MODE_APPEND: begin
        if (shadow_len >= lim) begin
          r.status = ST_FULL;
        end else begin
          shadow_list[shadow_len] = va;
          shadow_len++;
        end
      end
      MODE_REMOVE: begin
        if (int'(op.index) >= shadow_len) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (int i = int'(op.index); i < shadow_len - 1; i++)
            shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      MODE_FIND: begin
        pa = first_pos(va);
        if (pa < 0) r.status = ST_NOT_FOUND;
        else r.position = (pa > 31) ? 5'd31 : 5'(pa);
      end
      MODE_DIST: begin
        pa = first_pos(va);
        pb = first_pos(vb);
        if (pa < 0 || pb < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          d = pa - pb;
          if (d > 31) d = 31;
          if (d < -31) d = -31;
          r.difference = 6'(d);
        end
      end
      MODE_MINMAX: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          lo = shadow_list[0];
          hi = shadow_list[0];
          for (int i = 1; i < shadow_len; i++) begin
            if (shadow_list[i] < lo) lo = shadow_list[i];
            else if (shadow_list[i] > hi) hi = shadow_list[i];
          end
          r.min_value = lo;
          r.max_value = hi;
        end
      end
      MODE_REVERSE: begin
        for (int i = 0; i < shadow_len / 2; i++) begin
          t = shadow_list[i];
          shadow_list[i] = shadow_list[shadow_len-1-i];
          shadow_list[shadow_len-1-i] = t;
        end
      end
      default: ;
    endcase
    r.count = (shadow_len > 63) ? 6'd63 : 6'(shadow_len);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // driver: source side and sink back-pressure
  always @(negedge clk) begin : drive
    list_op_t op;
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst) begin
      if (s_tvalid && n_taken != n_sent) begin
        // transaction still waiting for acceptance
      end else if (op_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        op = op_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, op.index, op.value_b, op.value_a};
        s_tuser  <= op.mode;
        n_sent++;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin : observe
    list_op_t    op;
    list_reply_t got, want;
    if (rst) begin
      shadow_len = 0;
      shadow_cap = 6'd32;
      for (int i = 0; i < MAX_ENTRIES; i++) shadow_list[i] = '0;
    end else begin
      if (cfg_we) shadow_cap = cfg_wdata;
      if (m_tvalid && m_tready) begin
        got.status     = m_tuser;
        got.position   = m_tdata[4:0];
        got.difference = m_tdata[10:5];
        got.min_value  = m_tdata[42:11];
        got.max_value  = m_tdata[74:43];
        got.count      = m_tdata[80:75];
        if (reply_q.size() == 0) begin
          $error("reply transaction with nothing expected");
          errors++;
        end else begin
          want = reply_q.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("position", 32'(want.position), 32'(got.position));
          check_field("difference", 32'(want.difference), 32'(got.difference));
          check_field("min_value", want.min_value, got.min_value);
          check_field("max_value", want.max_value, got.max_value);
          check_field("count", 32'(want.count), 32'(got.count));
        end
      end
      if (s_tvalid && s_tready) begin
        op.mode    = s_tuser;
        op.value_a = s_tdata[31:0];
        op.value_b = s_tdata[63:32];
        op.index   = s_tdata[68:64];
        reply_q.push_back(apply_list_op(op));
        n_taken++;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall = 0;
      end else begin
        stall++;
        if (stall >= STALL_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  task automatic queue_op(logic [2:0] mode, logic signed [31:0] a, logic signed [31:0] b,
                          logic [4:0] idx);
    list_op_t op;
    int       lim;
    op  = '{mode: mode, value_a: a, value_b: b, index: idx};
    lim = (gen_cap < MAX_ENTRIES) ? int'(gen_cap) : MAX_ENTRIES;
    if (mode == MODE_APPEND && gen_len < lim) begin
      gen_len++;
      value_pool[$urandom_range(15)] = a;
    end
    if (mode == MODE_REMOVE && int'(idx) < gen_len) gen_len--;
    op_q.push_back(op);
    n_queued++;
  endtask

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r < 4) return value_pool[$urandom_range(15)];
    if (r < 6) begin
      case ($urandom_range(4))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom;
  endfunction

  task automatic queue_random_op();
    int          r;
    logic [4:0]  idx;
    r   = $urandom_range(99);
    idx = 5'($urandom_range(31));
    if (r < 30) begin
      queue_op(MODE_APPEND, pick_value(), $urandom, idx);
    end else if (r < 50) begin
      if (gen_len > 0 && $urandom_range(9) < 8) idx = 5'($urandom_range(gen_len - 1));
      queue_op(MODE_REMOVE, $urandom, $urandom, idx);
    end else if (r < 63) begin
      queue_op(MODE_FIND, pick_value(), $urandom, idx);
    end else if (r < 75) begin
      queue_op(MODE_DIST, pick_value(), pick_value(), idx);
    end else if (r < 85) begin
      queue_op(MODE_MINMAX, $urandom, $urandom, idx);
    end else if (r < 93) begin
      queue_op(MODE_REVERSE, $urandom, $urandom, idx);
    end else if (r < 97) begin
      queue_op($urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO, $urandom, $urandom, idx);
    end else begin
      // empty the list completely
      while (gen_len > 0)
        queue_op(MODE_REMOVE, $urandom, $urandom, 5'($urandom_range(gen_len - 1)));
    end
  endtask

  task automatic settle();
    while (!(n_taken == n_queued && reply_q.size() == 0)) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [5:0] cap);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    gen_cap    = cap;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [5:0] cap_set [8];
    int         target;
    cap_set = '{6'd63, 6'd3, 6'd0, 6'd32, 6'd1, 6'd16, 6'd2, 6'd20};
    for (int i = 0; i < 16; i++) value_pool[i] = $urandom;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty list corners
    queue_op(MODE_MINMAX, 32'h0, 32'h0, 5'd0);
    queue_op(MODE_REVERSE, 32'h0, 32'h0, 5'd0);
    queue_op(MODE_REMOVE, 32'h0, 32'h0, 5'd0);
    queue_op(MODE_FIND, 32'd5, 32'h0, 5'd0);
    queue_op(MODE_DIST, 32'd5, 32'd5, 5'd0);
    // extremes, duplicates
    queue_op(MODE_APPEND, 32'h8000_0000, 32'hFFFF_FFFF, 5'd31);
    queue_op(MODE_APPEND, 32'h7FFF_FFFF, 32'h0, 5'd0);
    queue_op(MODE_APPEND, 32'h0, 32'hFFFF_FFFF, 5'd31);
    queue_op(MODE_APPEND, 32'hFFFF_FFFF, 32'h0, 5'd0);
    queue_op(MODE_APPEND, 32'h7FFF_FFFF, 32'h0, 5'd0);
    queue_op(MODE_APPEND, 32'h8000_0000, 32'h0, 5'd0);
    queue_op(MODE_FIND, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd31);
    queue_op(MODE_DIST, 32'h0, 32'h8000_0000, 5'd0);
    queue_op(MODE_DIST, 32'h8000_0000, 32'hFFFF_FFFF, 5'd0);
    queue_op(MODE_DIST, 32'h0, 32'h0001_2345, 5'd0);
    queue_op(MODE_MINMAX, 32'h0, 32'h0, 5'd0);
    queue_op(MODE_REVERSE, 32'h0, 32'h0, 5'd0);
    queue_op(MODE_FIND, 32'h7FFF_FFFF, 32'h0, 5'd0);
    queue_op(MODE_MINMAX, 32'h0, 32'h0, 5'd0);
    queue_op(MODE_REMOVE, 32'h0, 32'h0, 5'd31);
    queue_op(MODE_REMOVE, 32'h0, 32'h0, 5'd5);
    queue_op(MODE_REMOVE, 32'h0, 32'h0, 5'd0);
    queue_op(MODE_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
    queue_op(MODE_SPARE_HI, 32'h0, 32'h0, 5'd0);
    // capacity dropped below the current length
    set_capacity(6'd2);
    queue_op(MODE_APPEND, 32'h1234_5678, 32'h0, 5'd0);
    queue_op(MODE_REMOVE, 32'h0, 32'h0, 5'd0);

    for (int regime = 0; regime < 3; regime++) begin
      for (int k = 0; k < 4; k++) begin
        set_capacity(cap_set[(regime * 4 + k) % 8]);
        case (regime)
          0: begin send_idle_pct = 9;  recv_idle_pct = 86; end
          1: begin send_idle_pct = 86; recv_idle_pct = 9;  end
          default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
        target = n_queued + OPS_PER_PHASE;
        while (n_queued < target) queue_random_op();
      end
    end

    while (!(n_taken == n_queued && reply_q.size() == 0)) @(posedge clk);
    repeat (MAX_ENTRIES + 8) @(posedge clk);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ble_pkg.sv
hw/rtl/ble_cell.sv
hw/rtl/bounded_list_engine_top.sv
sim/bounded_list_engine_top_tb.sv
